// ===== rtl/srml_pkg.sv =====
package srml_pkg;

  localparam int unsigned CAPACITY = 60;
  localparam int unsigned ItemW = 32;
  localparam int unsigned CountW = 6;
  localparam int unsigned ModeW = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_MARK  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_RESET = 2'd3
  } mode_e;

  typedef struct packed {
    logic              valid;
    logic [ItemW-1:0]  entry;
    logic              goes;
  } link_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== rtl/srml_cell.sv =====
module srml_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [31:0]         item_i,
  input  srml_pkg::cell_ctl_t        ctl_i,
  input  srml_pkg::link_t            prev_i,
  output srml_pkg::link_t            link_o,
  output logic                       eq_o,
  output logic                       gt_o
);
  import srml_pkg::*;

  logic              valid_q;
  logic [ItemW-1:0]  entry_q;
  logic              gt;

  assign gt     = valid_q && (item_i > $signed(entry_q));
  assign eq_o   = valid_q && (item_i == $signed(entry_q));
  assign gt_o   = gt;
  assign link_o = '{valid: valid_q, entry: entry_q, goes: (!valid_q || gt)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctl_i.shift) begin
      if (prev_i.goes) begin
        valid_q <= prev_i.valid;
      end else if (link_o.goes) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      if (prev_i.goes) begin
        entry_q <= prev_i.entry;
      end else if (link_o.goes) begin
        entry_q <= item_i;
      end
    end
  end

endmodule

// ===== rtl/sorted_read_mark_list.sv =====
// Mark, query and reset requests give their result in the cycle after acceptance.
// Throughput: one mark, query or reset request per cycle while the result is taken and no clear is in progress.
// Clear walks up to CAPACITY marks through the cell row, one per cycle, then responds.
// Reset (rst_ni low, asynchronous) empties the list and clears the sticky changed flag.
// The entry store itself is not cleared; only the per-cell valid bits are.
module sorted_read_mark_list #(
  parameter int unsigned CAPACITY = srml_pkg::CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] item_value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [0] unread_flag, [32:1] newest_read,
                                        // [38:33] entry_count, [39] changed
);
  import srml_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_CLEAR = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic              out_valid_q;
  logic              flag_q;
  logic [CntW-1:0]   count_q;
  logic              modified_q;
  logic [ItemW-1:0]  cur_q, last_q;

  logic              accept;
  mode_e             mode;
  logic signed [31:0] op_item;
  logic              mark_active, reset_req;
  logic              hit, any_gt, flag_c, changed_now, clear_done;
  cell_ctl_t         ctl;
  link_t             link_w [CAPACITY+1];
  logic [CAPACITY-1:0] eq_w, gt_w;
  logic signed [32:0] first_wide;
  logic [ItemW-1:0]  first_item;

  assign mode            = mode_e'(s_axis_tuser_i);
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign op_item     = (state_q == ST_CLEAR) ? $signed(cur_q) : $signed(s_axis_tdata_i);
  assign mark_active = (accept && (mode == MODE_MARK)) || (state_q == ST_CLEAR);
  assign reset_req   = accept && (mode == MODE_RESET);

  assign hit         = |eq_w;
  assign any_gt      = |gt_w;
  assign flag_c      = !hit && (!link_w[1].valid || any_gt);
  assign ctl.shift   = mark_active && !hit;
  assign ctl.clear   = reset_req;
  assign changed_now = ctl.shift && link_w[CAPACITY].goes;
  assign clear_done  = (state_q == ST_CLEAR) && (cur_q == last_q);

  assign link_w[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    srml_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .item_i (op_item),
      .ctl_i  (ctl),
      .prev_i (link_w[i]),
      .link_o (link_w[i+1]),
      .eq_o   (eq_w[i]),
      .gt_o   (gt_w[i])
    );
  end

  assign first_wide = {s_axis_tdata_i[31], s_axis_tdata_i} - 33'(CAPACITY - 1);
  assign first_item = (first_wide[32] != first_wide[31]) ? {1'b1, {(ItemW-1){1'b0}}}
                                                         : first_wide[31:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (mode == MODE_CLEAR)) begin
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (clear_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      flag_q      <= 1'b0;
      count_q     <= '0;
      modified_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear_done || (accept && (mode != MODE_CLEAR))) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        flag_q <= ((mode == MODE_MARK) || (mode == MODE_QUERY)) && flag_c;
      end
      if (reset_req) begin
        count_q    <= '0;
        modified_q <= 1'b0;
      end else if (changed_now) begin
        modified_q <= 1'b1;
        if (count_q != CntW'(CAPACITY)) begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (mode == MODE_CLEAR)) begin
      cur_q  <= first_item;
      last_q <= s_axis_tdata_i;
    end else if ((state_q == ST_CLEAR) && !clear_done) begin
      cur_q <= cur_q + 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {modified_q, 6'(count_q),
                            (link_w[1].valid ? link_w[1].entry : {ItemW{1'b0}}), flag_q};

endmodule

// ===== rtl/srml_checker.sv =====
module srml_checker #(
  parameter int unsigned CAPACITY = srml_pkg::CAPACITY
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);
  import srml_pkg::*;

  // hold a stalled response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("response dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("request taken while response stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (CAPACITY < 64) |-> m_axis_tdata_o[38:33] <= 6'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[38:33] != 6'd0) |-> m_axis_tdata_o[39])
    else $error("entries held without changed flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[38:33] == 6'd0) && (CAPACITY < 64)
      |-> m_axis_tdata_o[32:1] == 32'd0)
    else $error("empty list reports a newest entry");

endmodule

bind sorted_read_mark_list srml_checker #(.CAPACITY(CAPACITY)) u_srml_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
